// File: rtl/pmsl_pkg.sv
// Package for the PLM minmod slope limiter: widths, codes, job record and limiter helpers.
package pmsl_pkg;

   localparam int VARIABLES   = 4;
   localparam int DATA_W      = 32;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int DEN_W       = DATA_W + 2;
   localparam int FRAC_SHIFT  = 17;
   localparam int DIVIDEND_W  = DIFF_W + FRAC_SHIFT;
   localparam int RATIO_W     = 58;
   localparam int SCALED_W    = RATIO_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int VAR_W       = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;

   localparam logic [1:0] SLOPE_FACTOR_RESET = 2'd1;
   localparam logic [RATIO_W-1:0] HUGE_SLOPE = RATIO_W'(1) << 56;
   localparam logic signed [SCALED_W-1:0] SAT_MAX = SCALED_W'(64'sd2147483647);
   localparam logic signed [SCALED_W-1:0] SAT_MIN = SCALED_W'(-64'sd2147483648);

   typedef enum logic [1:0] {
      REG_SLOPE_FACTOR = 2'd0,
      REG_OWN_FIRST    = 2'd1,
      REG_OWN_LAST     = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      WIN_EMPTY,
      WIN_FIRST,
      WIN_INTERIOR
   } window_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_START,
      B_WAIT,
      B_STEP,
      B_LIMIT,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [DATA_W-1:0]                 left_width;
      logic [DATA_W-1:0]                 center_width;
      logic [DATA_W-1:0]                 right_width;
      logic [VARIABLES-1:0][DATA_W-1:0]  left_values;
      logic [VARIABLES-1:0][DATA_W-1:0]  center_values;
      logic [VARIABLES-1:0][DATA_W-1:0]  right_values;
      logic                              done;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [SCALED_W-1:0] mag_of(input logic signed [SCALED_W-1:0] v);
      return v[SCALED_W-1] ? SCALED_W'(-v) : v;
   endfunction

   function automatic logic opposite(input logic signed [SCALED_W-1:0] x,
                                     input logic signed [SCALED_W-1:0] y);
      return (x < 0 && y > 0) || (x > 0 && y < 0);
   endfunction

   function automatic logic signed [SCALED_W-1:0] limit3(
      input logic signed [SCALED_W-1:0] a,
      input logic signed [SCALED_W-1:0] b,
      input logic signed [SCALED_W-1:0] c);
      logic signed [SCALED_W-1:0] m;
      m = a;
      if (opposite(a, b)) m = '0;
      if (mag_of(b) < mag_of(m)) m = b;
      if (opposite(b, c)) m = '0;
      if (mag_of(c) < mag_of(m)) m = c;
      return m;
   endfunction

   function automatic logic signed [SCALED_W-1:0] scale_theta(
      input logic signed [RATIO_W-1:0] r,
      input logic [1:0] theta);
      logic signed [SCALED_W-1:0] x;
      logic signed [SCALED_W-1:0] y;
      x = SCALED_W'(r);
      case (theta)
         2'd0: y = '0;
         2'd1: y = x;
         2'd2: y = x <<< 1;
         default: y = x + (x <<< 1);
      endcase
      return y;
   endfunction

   function automatic logic [DATA_W-1:0] sat32(input logic signed [SCALED_W-1:0] v);
      logic signed [SCALED_W-1:0] t;
      t = v;
      if (v > SAT_MAX) t = SAT_MAX;
      if (v < SAT_MIN) t = SAT_MIN;
      return t[DATA_W-1:0];
   endfunction

endpackage

// File: rtl/pmsl_divider.sv
// Restoring serial divider, one quotient bit per cycle, with remainder.
module pmsl_divider #(
   parameter int N = pmsl_pkg::DIVIDEND_W,
   parameter int D = pmsl_pkg::DEN_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [D-1:0] remainder
);

   localparam int CNT_W = $clog2(N + 1);

   logic [N-1:0]     acc_ff, acc_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [D-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D:0]       trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, acc_ff[N-1]};
      ge      = trial >= {1'b0, dsr_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[N-2:0], ge};
         rem_in = ge ? D'(trial - {1'b0, dsr_ff}) : D'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/pmsl_queue.sv
// Short job queue between the window front end and the slope engine.
module pmsl_queue #(
   parameter int DEPTH = pmsl_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pmsl_pkg::job_type          push_job,
   input  logic                       pop,
   output pmsl_pkg::job_type          pop_job,
   output pmsl_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pmsl_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign pop_job      = entry_ff[rd_ff];
   assign status.full  = cnt_ff == CNT_W'(DEPTH);
   assign status.empty = cnt_ff == '0;

endmodule

// File: rtl/pmsl_front.sv
// Front end: takes requests, keeps the left/center window and issues slope jobs.
module pmsl_front (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_valid,
   output logic                                               req_stall,
   input  logic [pmsl_pkg::DATA_W-1:0]                        req_width,
   input  logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] req_values,
   input  logic                                               req_first,
   input  logic                                               req_last,
   input  logic                                               own_first,
   input  logic                                               own_last,
   input  pmsl_pkg::queue_status_type                         q_status,
   output logic                                               push,
   output pmsl_pkg::job_type                                  push_job
);

   pmsl_pkg::window_type seen_ff, seen_in, seen_now, seen_next;
   logic [pmsl_pkg::DATA_W-1:0] lw_ff, lw_in, cw_ff, cw_in;
   logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] lv_ff, lv_in, cv_ff, cv_in;
   logic              pend_ff, pend_in;
   pmsl_pkg::job_type pend_job_ff, pend_job_in;
   pmsl_pkg::job_type job1, job2;
   logic              accept, emit1, emit2;

   always_comb begin
      req_stall = pend_ff || q_status.full;
      accept    = req_valid && !req_stall;
      seen_now  = req_first ? pmsl_pkg::WIN_EMPTY : seen_ff;

      if (seen_now == pmsl_pkg::WIN_EMPTY) begin
         emit1     = 1'b0;
         lw_in     = req_width;
         cw_in     = req_width;
         lv_in     = req_values;
         cv_in     = req_values;
         seen_next = pmsl_pkg::WIN_FIRST;
      end else begin
         emit1     = (seen_now == pmsl_pkg::WIN_INTERIOR) || own_first;
         lw_in     = cw_ff;
         cw_in     = req_width;
         lv_in     = cv_ff;
         cv_in     = req_values;
         seen_next = pmsl_pkg::WIN_INTERIOR;
      end
      emit2 = req_last && own_last && ((seen_next == pmsl_pkg::WIN_INTERIOR) || own_first);

      job1.left_width    = lw_ff;
      job1.center_width  = cw_ff;
      job1.right_width   = req_width;
      job1.left_values   = lv_ff;
      job1.center_values = cv_ff;
      job1.right_values  = req_values;
      job1.done          = req_last && !emit2;

      // end cell mirrors itself as right neighbour
      job2.left_width    = lw_in;
      job2.center_width  = cw_in;
      job2.right_width   = cw_in;
      job2.left_values   = lv_in;
      job2.center_values = cv_in;
      job2.right_values  = cv_in;
      job2.done          = 1'b1;

      push     = (pend_ff && !q_status.full) || (accept && emit1);
      push_job = pend_ff ? pend_job_ff : job1;

      seen_in     = seen_ff;
      pend_in     = pend_ff;
      pend_job_in = pend_job_ff;
      if (accept) begin
         seen_in     = req_last ? pmsl_pkg::WIN_EMPTY : seen_next;
         pend_in     = emit2;
         pend_job_in = job2;
      end else if (pend_ff && !q_status.full) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_job_ff <= pend_job_in;
      if (reset) begin
         seen_ff <= pmsl_pkg::WIN_EMPTY;
         pend_ff <= 1'b0;
         lw_ff   <= '0;
         cw_ff   <= '0;
         lv_ff   <= '0;
         cv_ff   <= '0;
      end else begin
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         if (accept) begin
            lw_ff <= lw_in;
            cw_ff <= cw_in;
            lv_ff <= lv_in;
            cv_ff <= cv_in;
         end
      end
   end

endmodule

// File: rtl/pmsl_back.sv
// Slope engine: three ratios per variable on a shared divider, minmod, saturation, output register.
module pmsl_back (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic [1:0]                                         theta,
   input  pmsl_pkg::queue_status_type                         q_status,
   input  pmsl_pkg::job_type                                  pop_job,
   output logic                                               pop,
   output logic                                               rsp_valid,
   input  logic                                               rsp_stall,
   output logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] rsp_slopes,
   output logic                                               rsp_done
);

   localparam int VW = pmsl_pkg::VAR_W;
   localparam int RW = pmsl_pkg::RATIO_W;

   pmsl_pkg::back_state_type state_ff, state_in;
   pmsl_pkg::job_type        job_ff, job_in;
   logic [VW-1:0]            var_ff, var_in;
   logic [1:0]               k_ff, k_in;
   logic signed [RW-1:0]     ratio_ff [3];
   logic signed [RW-1:0]     ratio_in [3];
   logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] slope_ff, slope_in;
   logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] out_ff, out_in;
   logic                     out_done_ff, out_done_in;
   logic                     valid_ff, valid_in;
   logic                     load;

   logic signed [pmsl_pkg::DIFF_W-1:0] lv, cv, rv, diff;
   logic [pmsl_pkg::DEN_W-1:0]         den;
   logic                               neg;
   logic [pmsl_pkg::DIFF_W-1:0]        mag;
   logic [pmsl_pkg::DIVIDEND_W-1:0]    dividend;
   logic                               div_start, div_busy, div_done;
   logic [pmsl_pkg::DIVIDEND_W-1:0]    div_quot;
   logic [pmsl_pkg::DEN_W-1:0]         div_rem;
   logic [RW-1:0]                      rounded;

   pmsl_divider #(
      .N(pmsl_pkg::DIVIDEND_W),
      .D(pmsl_pkg::DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   always_comb begin
      lv = pmsl_pkg::DIFF_W'($signed(job_ff.left_values[var_ff]));
      cv = pmsl_pkg::DIFF_W'($signed(job_ff.center_values[var_ff]));
      rv = pmsl_pkg::DIFF_W'($signed(job_ff.right_values[var_ff]));
      case (k_ff)
         2'd0: begin
            diff = cv - lv;
            den  = pmsl_pkg::DEN_W'(job_ff.center_width) + pmsl_pkg::DEN_W'(job_ff.left_width);
         end
         2'd1: begin
            diff = rv - cv;
            den  = pmsl_pkg::DEN_W'(job_ff.right_width) + pmsl_pkg::DEN_W'(job_ff.center_width);
         end
         default: begin
            diff = rv - lv;
            den  = pmsl_pkg::DEN_W'(job_ff.left_width) + pmsl_pkg::DEN_W'(job_ff.right_width)
                 + (pmsl_pkg::DEN_W'(job_ff.center_width) << 1);
         end
      endcase
      neg      = diff[pmsl_pkg::DIFF_W-1];
      mag      = neg ? pmsl_pkg::DIFF_W'(-diff) : pmsl_pkg::DIFF_W'(diff);
      dividend = {mag, {pmsl_pkg::FRAC_SHIFT{1'b0}}};
      // round to nearest, ties away from zero
      rounded  = RW'(div_quot) + RW'({div_rem, 1'b0} >= {1'b0, den});
   end

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      var_in      = var_ff;
      k_in        = k_ff;
      ratio_in    = ratio_ff;
      slope_in    = slope_ff;
      out_in      = out_ff;
      out_done_in = out_done_ff;
      pop         = 1'b0;
      div_start   = 1'b0;
      load        = 1'b0;
      case (state_ff)
         pmsl_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = pop_job;
               var_in   = '0;
               k_in     = '0;
               state_in = pmsl_pkg::B_START;
            end
         end
         pmsl_pkg::B_START: begin
            if (den == '0) begin
               if (mag == '0) begin
                  ratio_in[k_ff] = '0;
               end else begin
                  ratio_in[k_ff] = neg ? RW'(-pmsl_pkg::HUGE_SLOPE) : pmsl_pkg::HUGE_SLOPE;
               end
               state_in = pmsl_pkg::B_STEP;
            end else begin
               div_start = 1'b1;
               state_in  = pmsl_pkg::B_WAIT;
            end
         end
         pmsl_pkg::B_WAIT: begin
            if (div_done) begin
               ratio_in[k_ff] = neg ? RW'(-rounded) : rounded;
               state_in       = pmsl_pkg::B_STEP;
            end
         end
         pmsl_pkg::B_STEP: begin
            if (k_ff == 2'd2) begin
               state_in = pmsl_pkg::B_LIMIT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = pmsl_pkg::B_START;
            end
         end
         pmsl_pkg::B_LIMIT: begin
            slope_in[var_ff] = pmsl_pkg::sat32(pmsl_pkg::limit3(
               pmsl_pkg::scale_theta(ratio_ff[0], theta),
               pmsl_pkg::SCALED_W'(ratio_ff[2]),
               pmsl_pkg::scale_theta(ratio_ff[1], theta)));
            if (var_ff == VW'(pmsl_pkg::VARIABLES - 1)) begin
               state_in = pmsl_pkg::B_OUT;
            end else begin
               var_in   = var_ff + 1'b1;
               k_in     = '0;
               state_in = pmsl_pkg::B_START;
            end
         end
         pmsl_pkg::B_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               load        = 1'b1;
               out_in      = slope_ff;
               out_done_in = job_ff.done;
               state_in    = pmsl_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = pmsl_pkg::B_IDLE;
         end
      endcase
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      var_ff      <= var_in;
      k_ff        <= k_in;
      ratio_ff    <= ratio_in;
      slope_ff    <= slope_in;
      out_ff      <= out_in;
      out_done_ff <= out_done_in;
      if (reset) begin
         state_ff <= pmsl_pkg::B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_slopes = out_ff;
   assign rsp_done   = out_done_ff;

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pmsl_pkg::B_WAIT)
      else $error("divider finished outside wait state");
`endif

endmodule

// File: rtl/plm_minmod_slope_limiter_top.sv
// Top level of the PLM generalized minmod slope limiter with its register port.
// Cells stream in one request per column position; a cell's limited slopes come out once its
// right neighbour is in, and the end cells (zero slope) only when their end is owned.
// A request is taken when the two-entry job queue has room and no second job is pending; a
// request that produces two results (the last of a column with its end owned) holds the input
// until its second job is queued. Each result costs twelve Q16.16 ratios on one shared
// bit-serial divider; each ratio has a setup state, the divider run (skipped for a zero width
// sum) and a step state, each variable a limit state, and each job a fetch and an output load state.
// Results wait in an output register while the engine moves on to the next job.
// Registers: 0x0 slope_factor (theta, reset 1), 0x4 own_first_cell (reset 1),
// 0x8 own_last_cell (reset 1). There is no clearing pass after reset.
module plm_minmod_slope_limiter_top #(
   parameter int QUEUE_DEPTH = pmsl_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [31:0]                           req_cell_width,
   input  logic signed [31:0]                    req_value_0,
   input  logic signed [31:0]                    req_value_1,
   input  logic signed [31:0]                    req_value_2,
   input  logic signed [31:0]                    req_value_3,
   input  logic                                  req_first_of_column,
   input  logic                                  req_last_of_column,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [31:0]                    rsp_slope_0,
   output logic signed [31:0]                    rsp_slope_1,
   output logic signed [31:0]                    rsp_slope_2,
   output logic signed [31:0]                    rsp_slope_3,
   output logic                                  rsp_column_done,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pmsl_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   logic [1:0] slope_factor_ff, slope_factor_in;
   logic       own_first_ff, own_first_in;
   logic       own_last_ff, own_last_in;
   logic       csr_write;
   pmsl_pkg::reg_index_type csr_index;

   logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] req_values;
   logic [pmsl_pkg::VARIABLES-1:0][pmsl_pkg::DATA_W-1:0] rsp_slopes;
   pmsl_pkg::queue_status_type q_status;
   pmsl_pkg::job_type          push_job, pop_job;
   logic                       push, pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = pmsl_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      slope_factor_in = slope_factor_ff;
      own_first_in    = own_first_ff;
      own_last_in     = own_last_ff;
      prdata          = '0;
      case (csr_index)
         pmsl_pkg::REG_SLOPE_FACTOR: begin
            prdata = {30'd0, slope_factor_ff};
            if (csr_write) slope_factor_in = pwdata[1:0];
         end
         pmsl_pkg::REG_OWN_FIRST: begin
            prdata = {31'd0, own_first_ff};
            if (csr_write) own_first_in = pwdata[0];
         end
         pmsl_pkg::REG_OWN_LAST: begin
            prdata = {31'd0, own_last_ff};
            if (csr_write) own_last_in = pwdata[0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_factor_ff <= pmsl_pkg::SLOPE_FACTOR_RESET;
         own_first_ff    <= 1'b1;
         own_last_ff     <= 1'b1;
      end else begin
         slope_factor_ff <= slope_factor_in;
         own_first_ff    <= own_first_in;
         own_last_ff     <= own_last_in;
      end
   end

   assign req_values[0] = req_value_0;
   assign req_values[1] = req_value_1;
   assign req_values[2] = req_value_2;
   assign req_values[3] = req_value_3;

   pmsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_width (req_cell_width),
      .req_values(req_values),
      .req_first (req_first_of_column),
      .req_last  (req_last_of_column),
      .own_first (own_first_ff),
      .own_last  (own_last_ff),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   pmsl_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .pop_job (pop_job),
      .status  (q_status)
   );

   pmsl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .theta     (slope_factor_ff),
      .q_status  (q_status),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_slopes(rsp_slopes),
      .rsp_done  (rsp_column_done)
   );

   assign rsp_slope_0 = rsp_slopes[0];
   assign rsp_slope_1 = rsp_slopes[1];
   assign rsp_slope_2 = rsp_slopes[2];
   assign rsp_slope_3 = rsp_slopes[3];

endmodule
